// ----- rtl/core/fhss_pkg.sv -----
// Shared types, constants and the phase decode for the floppy head stepper status block.
package fhss_pkg;

  localparam int unsigned NumDrives   = 2;
  localparam int unsigned PosWidth    = 11;
  localparam int unsigned StepWidth   = 10;
  localparam int unsigned TimerWidth  = 20;
  localparam int unsigned TrackWidth  = 7;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = 20;
  localparam int unsigned InWidth     = 16;
  localparam int unsigned OutWidth    = 32;

  localparam logic signed [PosWidth-1:0]   PosReset    = 11'sd376;
  localparam logic signed [PosWidth-1:0]   PosFloor    = -11'sd512;
  localparam logic signed [PosWidth:0]     TrackOrigin = 12'sd12;
  localparam logic signed [8:0]            TrackFirst  = -9'sd1;
  localparam logic signed [8:0]            TrackLast   = 9'sd45;
  localparam logic [TimerWidth-1:0]        TimerMax    = '1;

  localparam logic [StepWidth-1:0]  MaxStepReset  = 10'd432;
  localparam logic [StepWidth-1:0]  CalStepReset  = 10'd12;
  localparam logic [StepWidth-1:0]  HomeStepReset = 10'd376;
  localparam logic [TimerWidth-1:0] MotorDlyReset = 20'd240000;

  localparam logic [1:0] DriveBoth = 2'd2;
  localparam logic [1:0] DriveNone = 2'd3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgMaxStep  = 2'd0,
    CfgCalStep  = 2'd1,
    CfgHomeStep = 2'd2,
    CfgMotorDly = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SnsWrProt   = 2'd0,
    SnsEjLatch  = 2'd1,
    SnsCal      = 2'd2,
    SnsDiskIn   = 2'd3
  } sns_sel_e;

  typedef struct packed {
    logic       vld;
    logic [1:0] st;
  } phase_dec_t;

  // Quarter-step state from PH0..PH3 (bit3 = PH0); only two adjacent phases count.
  function automatic phase_dec_t phase_decode(input logic [3:0] ph);
    phase_dec_t res;
    res = '{vld: 1'b1, st: 2'd0};
    case (ph)
      4'b1100: res.st = 2'd0;
      4'b0110: res.st = 2'd1;
      4'b0011: res.st = 2'd2;
      4'b1001: res.st = 2'd3;
      default: res.vld = 1'b0;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/core/floppy_head_stepper_status.sv -----
// Top level: pin-sample decoder for head stepping, eject, motor delay and SNS status.
// Each input transfer's result is registered in the output register and shown in the next cycle.
// Throughput: one sample per cycle; the input is ready whenever the output register is
//   empty or being drained in the same cycle, so a stalled sink holds back only one result.
// Reset (rst_ni low, async): head counters to 376, config registers to their defaults,
//   all other state cleared, last selected drive set to none, output register empty.
module floppy_head_stepper_status (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [fhss_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [fhss_pkg::CfgWidth-1:0]     cfg_data_i,
  // pin samples
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [3:0] phase_lines, [4] head_select, [6:5] drive_enable_n, [8:7] motor_lines,
  // [10:9] eject_button_n, [12:11] disk_present, [14:13] write_protect, [15] unused
  input  logic [fhss_pkg::InWidth-1:0]      s_axis_tdata_i,
  // status results
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [0] sns, [2:1] drive_selected, [9:3] track, [20:10] head_position, [22:21] cal_flags,
  // [24:23] motor_on, [25] led, [27:26] eject_latched, [29:28] eject_event, [31:30] zero
  output logic [fhss_pkg::OutWidth-1:0]     m_axis_tdata_o
);
  import fhss_pkg::*;

  // ---------------- configuration registers ----------------
  logic [StepWidth-1:0]  max_step_q, cal_step_q, home_step_q;
  logic [TimerWidth-1:0] motor_dly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q  <= MaxStepReset;
      cal_step_q  <= CalStepReset;
      home_step_q <= HomeStepReset;
      motor_dly_q <= MotorDlyReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgMaxStep:  max_step_q  <= cfg_data_i[StepWidth-1:0];
        CfgCalStep:  cal_step_q  <= cfg_data_i[StepWidth-1:0];
        CfgHomeStep: home_step_q <= cfg_data_i[StepWidth-1:0];
        CfgMotorDly: motor_dly_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // limits as signed positions for compare against the head counters
  logic signed [PosWidth-1:0] max_pos, cal_pos, home_pos;
  assign max_pos  = $signed({1'b0, max_step_q});
  assign cal_pos  = $signed({1'b0, cal_step_q});
  assign home_pos = $signed({1'b0, home_step_q});

  // ---------------- handshake ----------------
  logic out_vld_q;
  logic in_fire;
  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------- input unpack ----------------
  logic [3:0] ph;
  logic       hds;
  logic [1:0] den_n, mt, btn_n, disk, wp;
  assign ph    = s_axis_tdata_i[3:0];
  assign hds   = s_axis_tdata_i[4];
  assign den_n = s_axis_tdata_i[6:5];
  assign mt    = s_axis_tdata_i[8:7];
  assign btn_n = s_axis_tdata_i[10:9];
  assign disk  = s_axis_tdata_i[12:11];
  assign wp    = s_axis_tdata_i[14:13];

  // ---------------- per-drive state ----------------
  logic signed [PosWidth-1:0] pos_q [NumDrives];
  logic signed [PosWidth-1:0] pos_d [NumDrives];
  logic [1:0]                 lphase_q [NumDrives];
  logic [1:0]                 lphase_d [NumDrives];
  logic [NumDrives-1:0]       resync_q, resync_d;
  logic [NumDrives-1:0]       ej_latch_q, ej_latch_d;
  logic [NumDrives-1:0]       motor_q, motor_d;
  logic [NumDrives-1:0]       armed_q, armed_d;
  logic [TimerWidth-1:0]      timer_q [NumDrives];
  logic [TimerWidth-1:0]      timer_d [NumDrives];
  logic [1:0]                 last_drv_q, last_drv_d;

  // ---------------- next state and result ----------------
  logic [1:0]                 drv_sel;
  logic                       single;
  logic                       dsel;
  phase_dec_t                 pdec;
  logic [1:0]                 delta;
  logic [TimerWidth-1:0]      tmr_inc;
  logic [NumDrives-1:0]       ev, cal;
  logic                       sns;
  logic signed [PosWidth:0]   trk_diff;
  logic signed [8:0]          trk_full;
  logic [TrackWidth-1:0]      trk;
  logic [PosWidth-1:0]        pos_out;

  always_comb begin
    // decode of the active-low selects: 0/1 single drive, 2 both, 3 none
    case (den_n)
      2'b01:   drv_sel = 2'd1;
      2'b10:   drv_sel = 2'd0;
      2'b00:   drv_sel = DriveBoth;
      default: drv_sel = DriveNone;
    endcase
    single = !drv_sel[1];
    dsel   = drv_sel[0];
    pdec   = phase_decode(ph);
    delta  = pdec.st - lphase_q[dsel];

    pos_d      = pos_q;
    lphase_d   = lphase_q;
    resync_d   = resync_q;
    ej_latch_d = ej_latch_q;
    motor_d    = motor_q;
    armed_d    = armed_q;
    timer_d    = timer_q;
    last_drv_d = last_drv_q;
    ev         = '0;
    cal        = '0;
    tmr_inc    = '0;

    // stepper: first valid pattern after a drive change (or after a bad one seen on a drive change) only records
    if (single) begin
      if (pdec.vld) begin
        if (resync_q[dsel] || (drv_sel != last_drv_q)) begin
          resync_d[dsel] = 1'b0;
        end else if (delta == 2'd1) begin
          if (pos_q[dsel] < max_pos) pos_d[dsel] = pos_q[dsel] + 11'sd1;
        end else if (delta == 2'd3) begin
          if (pos_q[dsel] > PosFloor) pos_d[dsel] = pos_q[dsel] - 11'sd1;
        end
        lphase_d[dsel] = pdec.st;
      end else if (drv_sel != last_drv_q) begin
        resync_d[dsel] = 1'b1;
      end
      last_drv_d = drv_sel;
    end

    // motor delay: timer runs while armed, saturating; change lands once it reaches delay
    for (int d = 0; d < NumDrives; d++) begin
      tmr_inc = timer_q[d];
      if (armed_q[d] && (timer_q[d] != TimerMax)) tmr_inc = timer_q[d] + 1'b1;
      timer_d[d] = tmr_inc;
      if (mt[d] != motor_q[d]) begin
        if (!armed_q[d]) begin
          armed_d[d] = 1'b1;
          timer_d[d] = '0;
        end else if (tmr_inc >= motor_dly_q) begin
          motor_d[d] = mt[d];
          armed_d[d] = 1'b0;
          timer_d[d] = '0;
        end
      end
    end

    // eject at the forward limit with a disk inserted
    if (single && (pos_d[dsel] >= max_pos) && disk[dsel]) begin
      pos_d[dsel]   = home_pos;
      motor_d[dsel] = 1'b0;
      ev[dsel]      = 1'b1;
    end

    // button latch, cleared by PH2 while selected; CAL from post-eject position
    for (int d = 0; d < NumDrives; d++) begin
      if (!btn_n[d]) begin
        ej_latch_d[d] = 1'b1;
      end else if (ph[1] && ((single && (dsel == d[0])) || (drv_sel == DriveBoth))) begin
        ej_latch_d[d] = 1'b0;
      end
      cal[d] = (pos_d[d] <= cal_pos);
    end

    // track = floor((pos - 12) / 8) clamped
    trk_diff = {pos_d[dsel][PosWidth-1], pos_d[dsel]} - TrackOrigin;
    trk_full = trk_diff[PosWidth:3];
    if (trk_full < TrackFirst)     trk_full = TrackFirst;
    else if (trk_full > TrackLast) trk_full = TrackLast;

    case (sns_sel_e'({ph[3], hds}))
      SnsWrProt:  sns = wp[dsel];
      SnsEjLatch: sns = ej_latch_d[dsel];
      SnsCal:     sns = cal[dsel];
      SnsDiskIn:  sns = disk[dsel] & !ev[dsel];
      default:    sns = 1'b0;
    endcase

    trk     = trk_full[TrackWidth-1:0];
    pos_out = pos_d[dsel];
    if (!single) begin
      sns     = 1'b0;
      trk     = '0;
      pos_out = '0;
    end
  end

  // ---------------- state registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < NumDrives; d++) begin
        pos_q[d]    <= PosReset;
        lphase_q[d] <= '0;
        timer_q[d]  <= '0;
      end
      resync_q   <= '0;
      ej_latch_q <= '0;
      motor_q    <= '0;
      armed_q    <= '0;
      last_drv_q <= DriveNone;
    end else if (in_fire) begin
      pos_q      <= pos_d;
      lphase_q   <= lphase_d;
      timer_q    <= timer_d;
      resync_q   <= resync_d;
      ej_latch_q <= ej_latch_d;
      motor_q    <= motor_d;
      armed_q    <= armed_d;
      last_drv_q <= last_drv_d;
    end
  end

  // ---------------- result register ----------------
  logic [OutWidth-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {2'b00, ev, ej_latch_d, |motor_d, motor_d, cal,
                     pos_out, trk, drv_sel, sns};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
